### design/sal_pkg.sv
`timescale 1ns / 1ps
package sal_pkg;

   localparam int MAX_LEN = 1024;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int LEN_W   = ADDR_W + 1;
   localparam int BYTE_W  = 8;
   localparam int START_W = 10;
   localparam int LCP_W   = 11;
   localparam int STAT_W  = 2;

   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_BAD   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_TRUNC = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_PASS, ST_SETUP, ST_FETCH, ST_DECIDE, ST_CMP, ST_CMPD,
      ST_EMIT, ST_RK0, ST_RK1, ST_K0, ST_K1, ST_K2, ST_K3, ST_KC, ST_KD, ST_KW,
      ST_Q0, ST_Q1
   } state_type;

endpackage

### design/sal_req_if.sv
`timescale 1ns / 1ps
interface sal_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] text_byte;
   logic       last_byte;
   logic [9:0] rank_index;

   modport source (output valid, mode, text_byte, last_byte, rank_index, input ready);
   modport sink   (input valid, mode, text_byte, last_byte, rank_index, output ready);
endinterface

### design/sal_rsp_if.sv
`timescale 1ns / 1ps
interface sal_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  suffix_start;
   logic [10:0] common_prefix;
   logic [1:0]  status;

   modport source (output valid, suffix_start, common_prefix, status, input ready);
   modport sink   (input valid, suffix_start, common_prefix, status, output ready);
endinterface

### design/sal_ram.sv
`timescale 1ns / 1ps
module sal_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [1<<ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### design/suffix_array_lcp_builder.sv
`timescale 1ns / 1ps
// Append: accepted while idle; any transaction waits while a result is held unread.
// Query: steps through states Q0 and Q1, then registers the result; a new request is taken only once back in idle.
// Build after the last byte: an init pass, ceil(log2 n) merge passes, a rank pass and an
// LCP pass; no input is accepted during the build.
// Reset (synchronous): empty text, not built, no overflow; memories are not cleared.
module suffix_array_lcp_builder (
   input  logic       clock,
   input  logic       reset,
   sal_req_if.sink    req,
   sal_rsp_if.source  rsp
);
   import sal_pkg::*;

   state_type state_ff, state_in;

   logic [LEN_W-1:0] len_ff, len_in;
   logic             built_ff, built_in;
   logic             ovf_ff, ovf_in;
   logic             src_ff, src_in;
   logic [LEN_W-1:0] width_ff, width_in;
   logic [LEN_W:0]   lo_ff, lo_in;
   logic [LEN_W-1:0] mid_ff, mid_in, hi_ff, hi_in;
   logic [LEN_W-1:0] p_ff, p_in, q_ff, q_in, k_ff, k_in;
   logic [LEN_W-1:0] ca_ff, ca_in, cb_ff, cb_in, h_ff, h_in;
   logic [ADDR_W-1:0] r_ff, r_in;
   logic             less_ff, less_in;

   logic             out_valid_ff, out_valid_in;
   logic [START_W-1:0] out_start_ff, out_start_in;
   logic [LCP_W-1:0]   out_lcp_ff, out_lcp_in;
   logic [STAT_W-1:0]  out_stat_ff, out_stat_in;

   // memory ports
   logic              txt_we;
   logic [ADDR_W-1:0] txt_wa;
   logic [BYTE_W-1:0] ta_rd, tb_rd;
   logic              orda_we, ordb_we;
   logic [ADDR_W-1:0] ord_wa;
   logic [ADDR_W-1:0] ord_wd;
   logic [ADDR_W-1:0] orda_p, orda_q, ordb_p, ordb_q, ord_p, ord_q;
   logic              rnk_we;
   logic [ADDR_W-1:0] rnk_rd;
   logic              pfx_we;
   logic [LCP_W-1:0]  pfx_rd;

   logic accept;
   logic p_live, q_live;
   logic [LEN_W:0] w2, mid_sum, hi_sum;

   assign req.ready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign ord_p     = src_ff ? ordb_p : orda_p;
   assign ord_q     = src_ff ? ordb_q : orda_q;
   assign p_live    = p_ff < mid_ff;
   assign q_live    = q_ff < hi_ff;
   assign w2        = {width_ff, 1'b0};
   assign mid_sum   = lo_ff + {1'b0, width_ff};
   assign hi_sum    = lo_ff + w2;

   sal_ram #(.WIDTH(BYTE_W), .ADDR_W(ADDR_W)) u_txt_a (.clock, .wr_en(txt_we),
      .wr_addr(txt_wa), .wr_data(req.text_byte), .rd_addr(ca_ff[ADDR_W-1:0]),
      .rd_data(ta_rd));
   sal_ram #(.WIDTH(BYTE_W), .ADDR_W(ADDR_W)) u_txt_b (.clock, .wr_en(txt_we),
      .wr_addr(txt_wa), .wr_data(req.text_byte), .rd_addr(cb_ff[ADDR_W-1:0]),
      .rd_data(tb_rd));
   sal_ram #(.WIDTH(ADDR_W), .ADDR_W(ADDR_W)) u_orda_p (.clock, .wr_en(orda_we),
      .wr_addr(ord_wa), .wr_data(ord_wd), .rd_addr(p_ff[ADDR_W-1:0]), .rd_data(orda_p));
   sal_ram #(.WIDTH(ADDR_W), .ADDR_W(ADDR_W)) u_orda_q (.clock, .wr_en(orda_we),
      .wr_addr(ord_wa), .wr_data(ord_wd), .rd_addr(q_ff[ADDR_W-1:0]), .rd_data(orda_q));
   sal_ram #(.WIDTH(ADDR_W), .ADDR_W(ADDR_W)) u_ordb_p (.clock, .wr_en(ordb_we),
      .wr_addr(ord_wa), .wr_data(ord_wd), .rd_addr(p_ff[ADDR_W-1:0]), .rd_data(ordb_p));
   sal_ram #(.WIDTH(ADDR_W), .ADDR_W(ADDR_W)) u_ordb_q (.clock, .wr_en(ordb_we),
      .wr_addr(ord_wa), .wr_data(ord_wd), .rd_addr(q_ff[ADDR_W-1:0]), .rd_data(ordb_q));
   sal_ram #(.WIDTH(ADDR_W), .ADDR_W(ADDR_W)) u_rank (.clock, .wr_en(rnk_we),
      .wr_addr(ord_p), .wr_data(p_ff[ADDR_W-1:0]), .rd_addr(k_ff[ADDR_W-1:0]),
      .rd_data(rnk_rd));
   sal_ram #(.WIDTH(LCP_W), .ADDR_W(ADDR_W)) u_pfx (.clock, .wr_en(pfx_we),
      .wr_addr(r_ff), .wr_data(h_ff), .rd_addr(p_ff[ADDR_W-1:0]), .rd_data(pfx_rd));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.mode == MODE_QUERY) state_in = ST_Q0;
               else if (req.last_byte) state_in = ST_INIT;
            end
         end
         ST_INIT:   if (p_ff + 1'b1 >= len_ff) state_in = ST_PASS;
         ST_PASS:   state_in = (width_ff >= len_ff) ? ST_RK0 : ST_SETUP;
         ST_SETUP:  state_in = (lo_ff >= {1'b0, len_ff}) ? ST_PASS : ST_FETCH;
         ST_FETCH:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (p_live && q_live) state_in = ST_CMP;
            else if (p_live || q_live) state_in = ST_FETCH;
            else state_in = ST_SETUP;
         end
         ST_CMP: begin
            if (ca_ff >= len_ff || cb_ff >= len_ff) state_in = ST_EMIT;
            else state_in = ST_CMPD;
         end
         ST_CMPD:   state_in = (ta_rd != tb_rd) ? ST_EMIT : ST_CMP;
         ST_EMIT:   state_in = ST_FETCH;
         ST_RK0:    state_in = (p_ff >= len_ff) ? ST_K0 : ST_RK1;
         ST_RK1:    state_in = ST_RK0;
         ST_K0:     state_in = (k_ff >= len_ff) ? ST_IDLE : ST_K1;
         ST_K1:     state_in = (rnk_rd == '0) ? ST_KW : ST_K2;
         ST_K2:     state_in = ST_K3;
         ST_K3:     state_in = ST_KC;
         ST_KC:     state_in = (ca_ff < len_ff && cb_ff < len_ff) ? ST_KD : ST_KW;
         ST_KD:     state_in = (ta_rd == tb_rd) ? ST_KC : ST_KW;
         ST_KW:     state_in = ST_K0;
         ST_Q0:     state_in = ST_Q1;
         ST_Q1:     state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      len_in = len_ff;   built_in = built_ff; ovf_in = ovf_ff;  src_in = src_ff;
      width_in = width_ff; lo_in = lo_ff; mid_in = mid_ff; hi_in = hi_ff;
      p_in = p_ff; q_in = q_ff; k_in = k_ff; ca_in = ca_ff; cb_in = cb_ff;
      h_in = h_ff; r_in = r_ff; less_in = less_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_start_in = out_start_ff; out_lcp_in = out_lcp_ff; out_stat_in = out_stat_ff;
      txt_we = 1'b0; txt_wa = len_ff[ADDR_W-1:0];
      orda_we = 1'b0; ordb_we = 1'b0;
      ord_wa = k_ff[ADDR_W-1:0]; ord_wd = ord_p;
      rnk_we = 1'b0; pfx_we = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.mode == MODE_QUERY) begin
                  p_in = {1'b0, req.rank_index};
               end else begin
                  if (built_ff) begin
                     built_in = 1'b0;
                     ovf_in   = 1'b0;
                     txt_we   = 1'b1;
                     txt_wa   = '0;
                     len_in   = LEN_W'(1);
                  end else if (len_ff < LEN_W'(MAX_LEN)) begin
                     txt_we = 1'b1;
                     len_in = len_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  p_in     = '0;
                  width_in = LEN_W'(1);
                  src_in   = 1'b0;
               end
            end
         end
         ST_INIT: begin
            orda_we = 1'b1;
            ord_wa  = p_ff[ADDR_W-1:0];
            ord_wd  = p_ff[ADDR_W-1:0];
            p_in    = p_ff + 1'b1;
         end
         ST_PASS: begin
            lo_in = '0;
            p_in  = '0;
         end
         ST_SETUP: begin
            if (lo_ff >= {1'b0, len_ff}) begin
               width_in = {width_ff[LEN_W-2:0], 1'b0};
               src_in   = !src_ff;
            end else begin
               mid_in = (mid_sum > {1'b0, len_ff}) ? len_ff : mid_sum[LEN_W-1:0];
               hi_in  = (hi_sum > {1'b0, len_ff}) ? len_ff : hi_sum[LEN_W-1:0];
               p_in   = lo_ff[LEN_W-1:0];
               k_in   = lo_ff[LEN_W-1:0];
               q_in   = (mid_sum > {1'b0, len_ff}) ? len_ff : mid_sum[LEN_W-1:0];
            end
         end
         ST_DECIDE: begin
            if (p_live && q_live) begin
               ca_in = {1'b0, ord_q};
               cb_in = {1'b0, ord_p};
            end else if (p_live) begin
               orda_we = src_ff;  ordb_we = !src_ff;
               ord_wd = ord_p; p_in = p_ff + 1'b1; k_in = k_ff + 1'b1;
            end else if (q_live) begin
               orda_we = src_ff;  ordb_we = !src_ff;
               ord_wd = ord_q; q_in = q_ff + 1'b1; k_in = k_ff + 1'b1;
            end else begin
               lo_in = hi_sum;
            end
         end
         ST_CMP: begin
            less_in = (ca_ff >= len_ff) && (cb_ff < len_ff);
         end
         ST_CMPD: begin
            less_in = ta_rd < tb_rd;
            if (ta_rd == tb_rd) begin
               ca_in = ca_ff + 1'b1;
               cb_in = cb_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            orda_we = src_ff;  ordb_we = !src_ff;
            k_in = k_ff + 1'b1;
            // the suffix at q wins only when strictly smaller
            if (less_ff) begin
               ord_wd = ord_q; q_in = q_ff + 1'b1;
            end else begin
               ord_wd = ord_p; p_in = p_ff + 1'b1;
            end
         end
         ST_RK0: begin
            k_in = '0;
            h_in = '0;
         end
         ST_RK1: begin
            rnk_we = 1'b1;
            p_in   = p_ff + 1'b1;
         end
         ST_K0: begin
            if (k_ff >= len_ff) built_in = 1'b1;
         end
         ST_K1: begin
            r_in = rnk_rd;
            q_in = {1'b0, rnk_rd - 1'b1};
            if (rnk_rd == '0) h_in = '0;
         end
         ST_K3: begin
            ca_in = k_ff + h_ff;
            cb_in = {1'b0, ord_q} + h_ff;
         end
         ST_KD: begin
            if (ta_rd == tb_rd) begin
               h_in  = h_ff + 1'b1;
               ca_in = ca_ff + 1'b1;
               cb_in = cb_ff + 1'b1;
            end
         end
         ST_KW: begin
            pfx_we = 1'b1;
            if (h_ff != '0) h_in = h_ff - 1'b1;
            k_in = k_ff + 1'b1;
         end
         ST_Q1: begin
            out_valid_in = 1'b1;
            if (!built_ff || p_ff >= len_ff) begin
               out_start_in = '0;
               out_lcp_in   = '0;
               out_stat_in  = STATUS_BAD;
            end else begin
               out_start_in = START_W'(ord_p);
               out_lcp_in   = pfx_rd;
               out_stat_in  = ovf_ff ? STATUS_TRUNC : STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         built_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         built_ff     <= built_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
      src_ff <= src_in;   width_ff <= width_in; lo_ff <= lo_in;
      mid_ff <= mid_in;   hi_ff <= hi_in;
      p_ff <= p_in;       q_ff <= q_in;         k_ff <= k_in;
      ca_ff <= ca_in;     cb_ff <= cb_in;       h_ff <= h_in;
      r_ff <= r_in;       less_ff <= less_in;
      out_start_ff <= out_start_in;
      out_lcp_ff   <= out_lcp_in;
      out_stat_ff  <= out_stat_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.suffix_start  = out_start_ff;
   assign rsp.common_prefix = out_lcp_ff;
   assign rsp.status        = out_stat_ff;

`ifndef SYNTHESIS
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_Q1)
      else $error("result raised outside query completion");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_stat_ff == STATUS_BAD |-> out_start_ff == '0 && out_lcp_ff == '0)
      else $error("rejected query carries payload");
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready)
      else $error("ready while building or querying");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_LEN))
      else $error("text length beyond capacity");
`endif
endmodule
